// ===== design/slte_pkg.sv =====
// ----------------------------------------------------------------------------
// slte_pkg: shared types and constants
// Holds the decoded sprite attributes, the tile unit control group and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package slte_pkg;

  localparam int CodeW  = 13;
  localparam int PosW   = 11;
  localparam int ColorW = 4;

  // Configuration register indexes
  localparam logic [1:0] CfgFlipScreen    = 2'd0;
  localparam logic [1:0] CfgPriorityMask  = 2'd1;
  localparam logic [1:0] CfgPriorityValue = 2'd2;

  localparam logic [PosW-1:0] ScreenOffset = 11'd240;

  // flags: bit0 flip x out, bit1 flip y out, bit2 flash, bit3 flip y as written
  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [ColorW-1:0] color;
    logic [3:0]        flags;
    logic [1:0]        hlog;
    logic [PosW-1:0]   x;
    logic [PosW-1:0]   y;
  } sprite_attr_t;

  typedef struct packed {
    logic load;
    logic step;
  } tile_ctrl_t;

endpackage

// ===== design/slte_head_decode.sv =====
// ----------------------------------------------------------------------------
// slte_head_decode: sprite head entry decoder
// Turns the three entry words of a head into aligned base code, color,
// flags and screen positions, with flip-screen mirroring.
// ----------------------------------------------------------------------------
module slte_head_decode (
  input  logic [15:0]           attr_word_i,
  input  logic [15:0]           tile_word_i,
  input  logic [15:0]           pos_word_i,
  input  logic                  flip_screen_i,
  output slte_pkg::sprite_attr_t attr_o,
  output logic [1:0]            wlog_o
);
  import slte_pkg::*;

  logic [1:0]       hlog;
  logic [CodeW-1:0] hmask;
  logic [CodeW-1:0] code_al;
  logic             fx;
  logic             fy;
  logic [PosW-1:0]  px;
  logic [PosW-1:0]  py;

  always_comb begin
    hlog    = attr_word_i[12:11];
    hmask   = (13'd1 << hlog) - 13'd1;
    code_al = tile_word_i[CodeW-1:0] & ~hmask;
    fy      = attr_word_i[14];
    fx      = attr_word_i[13] ^ flip_screen_i;
    // sign-extend the 9-bit positions
    px      = {{2{pos_word_i[8]}}, pos_word_i[8:0]};
    py      = {{2{attr_word_i[8]}}, attr_word_i[8:0]};

    attr_o.code  = fy ? code_al : (code_al | hmask);
    attr_o.color = pos_word_i[15:12];
    attr_o.flags = {fy, pos_word_i[11], fy ^ flip_screen_i, fx};
    attr_o.hlog  = hlog;
    // 240 - (240 - p) folds back to p under flip screen
    attr_o.x     = flip_screen_i ? px : (ScreenOffset - px);
    attr_o.y     = flip_screen_i ? py : (ScreenOffset - py);
    wlog_o       = attr_word_i[10:9];
  end

endmodule

// ===== design/slte_tile_unit.sv =====
// ----------------------------------------------------------------------------
// slte_tile_unit: iterative tile command generator
// Loads the start of one column, then steps code and y once per tile.
// ----------------------------------------------------------------------------
module slte_tile_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slte_pkg::tile_ctrl_t   ctrl_i,
  input  slte_pkg::sprite_attr_t attr_i,
  input  logic [2:0]             col_i,
  output logic [12:0]            code_o,
  output logic [10:0]            x_o,
  output logic [10:0]            y_o,
  output logic                   last_o
);
  import slte_pkg::*;

  logic [CodeW-1:0] code_q, code_d;
  logic [PosW-1:0]  x_q, x_d;
  logic [PosW-1:0]  y_q, y_d;
  logic [2:0]       row_q, row_d;
  logic             fscreen;
  logic [PosW-1:0]  col_off;
  logic [CodeW-1:0] col_code;
  logic [2:0]       row_max;

  always_comb begin
    fscreen  = attr_i.flags[1] ^ attr_i.flags[3];
    col_off  = {4'b0, col_i, 4'b0};
    col_code = {10'b0, col_i} << attr_i.hlog;
    row_max  = 3'((4'd1 << attr_i.hlog) - 4'd1);
    code_d   = code_q;
    x_d      = x_q;
    y_d      = y_q;
    row_d    = row_q;
    if (ctrl_i.load) begin
      code_d = attr_i.code + col_code;
      x_d    = fscreen ? (attr_i.x + col_off) : (attr_i.x - col_off);
      y_d    = attr_i.y;
      row_d  = 3'd0;
    end else if (ctrl_i.step) begin
      code_d = attr_i.flags[3] ? (code_q + 13'd1) : (code_q - 13'd1);
      y_d    = fscreen ? (y_q + 11'd16) : (y_q - 11'd16);
      row_d  = row_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 3'd0;
    end else begin
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    x_q    <= x_d;
    y_q    <= y_d;
  end

  assign code_o = code_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign last_o = (row_q == row_max);

endmodule

// ===== design/sprite_list_tile_emitter.sv =====
// ----------------------------------------------------------------------------
// sprite_list_tile_emitter: sprite list entry to tile draw commands
// Decodes head entries, tracks continuation columns and emits one column of
// up to eight tile commands per entry.
//
//   channel  | dir | signals                              | contents
//   s_axis   | in  | tvalid tready tdata[47:0] tuser[1:0] | one list entry
//   m_axis   | out | tvalid tready tdata[47:0] tlast      | one tile command
//   cfg      | in  | cfg_we_i cfg_idx_i cfg_data_i        | register write
//
// An entry is handled in steps: accept, column setup, then h tiles (h = 1,
// 2, 4 or 8 tile rows) at one tile per cycle while the output is not stalled,
// from the shared code/position step unit; a suppressed column ends at
// setup. Output stalls hold the current tile. Reset clears the sequencer,
// column counters and registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sprite_list_tile_emitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // attr_word[15:0], tile_word[31:16], pos_word[47:32]
  input  logic [47:0] s_axis_tdata,
  // odd_frame[0], first_of_list[1]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tile_code[12:0], palette_color[16:13], flip_x[17], flip_y[18],
  // screen_x[29:19], screen_y[40:30], zero[47:41]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i
);
  import slte_pkg::*;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSetup = 3'b010,
    StEmit  = 3'b100
  } state_e;

  state_e       state_q, state_d;
  logic         flip_screen_q;
  logic [3:0]   prio_mask_q;
  logic [3:0]   prio_value_q;
  logic [2:0]   cols_left_q, cols_left_d;
  logic [2:0]   col_idx_q, col_idx_d;
  logic [2:0]   col_q, col_d;
  logic         odd_q;
  sprite_attr_t saved_q, saved_d;
  sprite_attr_t head_attr;
  logic [1:0]   wlog;
  tile_ctrl_t   ctrl;
  logic         in_acc;
  logic         out_acc;
  logic         is_head;
  logic         suppress;
  logic [12:0]  tile_code;
  logic [10:0]  tile_x;
  logic [10:0]  tile_y;
  logic         tile_last;

  slte_head_decode u_decode (
    .attr_word_i   (s_axis_tdata[15:0]),
    .tile_word_i   (s_axis_tdata[31:16]),
    .pos_word_i    (s_axis_tdata[47:32]),
    .flip_screen_i (flip_screen_q),
    .attr_o        (head_attr),
    .wlog_o        (wlog)
  );

  slte_tile_unit u_tile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .attr_i (saved_q),
    .col_i  (col_q),
    .code_o (tile_code),
    .x_o    (tile_x),
    .y_o    (tile_y),
    .last_o (tile_last)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StEmit);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign is_head       = s_axis_tuser[1] || s_axis_tdata[15] || (cols_left_q == 3'd0);
  assign suppress      = ((saved_q.color & prio_mask_q) != prio_value_q)
                         || (saved_q.flags[2] && !odd_q);

  assign m_axis_tdata  = {7'b0, tile_y, tile_x, saved_q.flags[1], saved_q.flags[0],
                          saved_q.color, tile_code};
  assign m_axis_tlast  = tile_last;

  always_comb begin
    state_d     = state_q;
    cols_left_d = cols_left_q;
    col_idx_d   = col_idx_q;
    col_d       = col_q;
    saved_d     = saved_q;
    ctrl        = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (is_head) begin
            saved_d     = head_attr;
            col_d       = 3'd0;
            cols_left_d = 3'((4'd1 << wlog) - 4'd1);
            col_idx_d   = 3'd1;
          end else begin
            col_d       = col_idx_q;
            col_idx_d   = col_idx_q + 3'd1;
            cols_left_d = cols_left_q - 3'd1;
          end
          state_d = StSetup;
        end
      end
      StSetup: begin
        // a suppressed column still uses up its slot
        if (suppress) begin
          state_d = StIdle;
        end else begin
          ctrl.load = 1'b1;
          state_d   = StEmit;
        end
      end
      StEmit: begin
        if (out_acc) begin
          if (tile_last) begin
            state_d = StIdle;
          end else begin
            ctrl.step = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      flip_screen_q <= 1'b0;
      prio_mask_q   <= 4'd0;
      prio_value_q  <= 4'd0;
      cols_left_q   <= 3'd0;
      col_idx_q     <= 3'd0;
      col_q         <= 3'd0;
      odd_q         <= 1'b0;
      saved_q       <= '0;
    end else begin
      state_q     <= state_d;
      cols_left_q <= cols_left_d;
      col_idx_q   <= col_idx_d;
      col_q       <= col_d;
      saved_q     <= saved_d;
      if (in_acc) begin
        odd_q <= s_axis_tuser[0];
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFlipScreen:    flip_screen_q <= cfg_data_i[0];
          CfgPriorityMask:  prio_mask_q   <= cfg_data_i;
          CfgPriorityValue: prio_value_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Sequencer checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a tile is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready && !m_axis_tvalid)
    else $error("column setup cycle skipped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tlast |=> !m_axis_tvalid)
    else $error("tile emitted past end of column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !m_axis_tlast |=> m_axis_tvalid)
    else $error("column ended before its last tile");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: sprite list tile emitter testbench
// Streams sprite list entries into the emitter with random gaps and output
// stalls. A predictor decodes each accepted entry the way the emitter should
// and queues the tile commands it must produce. Every accepted tile command
// is checked field by field against the oldest queued one. The run steps
// through several flip-screen and priority settings, including their
// extremes, and starts with a directed set of entries.
// ----------------------------------------------------------------------------
module tb;
  import slte_pkg::*;

  localparam int ScreenRef = 240;

  typedef struct packed {
    logic [15:0] attr_w;
    logic [15:0] tile_w;
    logic [15:0] pos_w;
    logic        odd;
    logic        first;
  } list_entry_t;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [ColorW-1:0] color;
    logic              fx;
    logic              fy;
    logic [PosW-1:0]   sx;
    logic [PosW-1:0]   sy;
    logic              last;
  } tile_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // attr_word[15:0], tile_word[31:16], pos_word[47:32]
  logic [1:0]  s_axis_tuser;   // odd_frame[0], first_of_list[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tile_code[12:0], palette_color[16:13], flip_x[17], flip_y[18],
  // screen_x[29:19], screen_y[40:30], zero[47:41]
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [3:0]  cfg_data_i;

  // Predictor copy of the registers and the sprite state
  logic              cfg_flip;
  logic [3:0]        cfg_prio_mask;
  logic [3:0]        cfg_prio_value;
  logic [2:0]        cols_left;
  logic [2:0]        col_idx;
  logic [CodeW-1:0]  spr_code;
  logic [ColorW-1:0] spr_color;
  logic [3:0]        spr_flags;
  logic [1:0]        spr_hlog;
  logic [PosW-1:0]   spr_x;
  logic [PosW-1:0]   spr_y;

  list_entry_t entry_q[$];
  tile_cmd_t   tiles_due[$];
  int          entries_made;
  int          err_count;
  int          entry_gap;
  int          ready_stall;
  bit          send_burst;
  bit          recv_burst;
  logic        entry_taken;
  logic        tile_taken;

  sprite_list_tile_emitter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  task automatic note_error(string msg);
    if (err_count < 10) $display("%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic push_column(int col, bit odd);
    int        rows;
    int        code;
    int        px;
    int        py;
    int        step;
    tile_cmd_t t;
    rows = 1 << spr_hlog;
    // flip screen is recovered from the flip-y out and flip-y written bits
    step = (spr_flags[1] ^ spr_flags[3]) ? 16 : -16;
    if ((spr_color & cfg_prio_mask) != cfg_prio_value) return;
    if (spr_flags[2] && !odd) return;
    for (int r = 0; r < rows; r++) begin
      code = spr_code + rows * col;
      code = spr_flags[3] ? code + r : code - r;
      px = $signed(spr_x) + step * col;
      py = $signed(spr_y) + step * r;
      t.code  = code[CodeW-1:0];
      t.color = spr_color;
      t.fx    = spr_flags[0];
      t.fy    = spr_flags[1];
      t.sx    = px[PosW-1:0];
      t.sy    = py[PosW-1:0];
      t.last  = (r == rows - 1);
      tiles_due.push_back(t);
    end
  endtask

  task automatic predict_tiles(list_entry_t e);
    int               rows;
    int               sx;
    int               sy;
    logic [CodeW-1:0] code;
    bit               fx;
    bit               fy;
    if (e.first || e.attr_w[15] || cols_left == 0) begin
      spr_hlog = e.attr_w[12:11];
      rows = 1 << spr_hlog;
      fx = e.attr_w[13];
      fy = e.attr_w[14];
      sx = ScreenRef - $signed(e.pos_w[8:0]);
      sy = ScreenRef - $signed(e.attr_w[8:0]);
      code = e.tile_w[CodeW-1:0] & ~CodeW'(rows - 1);
      if (!fy) code = code + CodeW'(rows - 1);
      if (cfg_flip) begin
        sx = ScreenRef - sx;
        sy = ScreenRef - sy;
        fx = !fx;
      end
      spr_code  = code;
      spr_color = e.pos_w[15:12];
      spr_flags = {fy, e.pos_w[11], fy ^ cfg_flip, fx};
      spr_x     = sx[PosW-1:0];
      spr_y     = sy[PosW-1:0];
      push_column(0, e.odd);
      cols_left = 3'((1 << e.attr_w[10:9]) - 1);
      col_idx   = 3'd1;
    end else begin
      push_column(col_idx, e.odd);
      col_idx++;
      cols_left--;
    end
  endtask

  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) note_error($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  // ------------------------------------------------------------ driver/monitor

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(8);
  endfunction

  always @(negedge clk_i) begin
    list_entry_t ent;
    if (rst_ni && (!s_axis_tvalid || entry_taken)) begin
      if (entry_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        entry_gap <= entry_gap - 1;
      end else if (entry_q.size() != 0) begin
        ent = entry_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ent.pos_w, ent.tile_w, ent.attr_w};
        s_axis_tuser <= {ent.first, ent.odd};
        if ($urandom_range(29) == 0) send_burst <= !send_burst;
        entry_gap <= draw_gap(send_burst);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    int stall;
    if (rst_ni) begin
      if (tile_taken) begin
        if ($urandom_range(29) == 0) recv_burst <= !recv_burst;
        stall = draw_gap(recv_burst);
        m_axis_tready <= (stall == 0);
        ready_stall <= (stall == 0) ? 0 : stall - 1;
      end else if (ready_stall > 0) begin
        m_axis_tready <= 1'b0;
        ready_stall <= ready_stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    tile_cmd_t   want;
    list_entry_t ent;
    entry_taken <= s_axis_tvalid && s_axis_tready;
    tile_taken <= m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFlipScreen:    cfg_flip = cfg_data_i[0];
          CfgPriorityMask:  cfg_prio_mask = cfg_data_i;
          CfgPriorityValue: cfg_prio_value = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (tiles_due.size() == 0) begin
          note_error($sformatf("unexpected tile command %h last %b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = tiles_due.pop_front();
          cmp_field("tile_code", want.code, m_axis_tdata[12:0]);
          cmp_field("palette_color", want.color, m_axis_tdata[16:13]);
          cmp_field("flip_x", want.fx, m_axis_tdata[17]);
          cmp_field("flip_y", want.fy, m_axis_tdata[18]);
          cmp_field("screen_x", want.sx, m_axis_tdata[29:19]);
          cmp_field("screen_y", want.sy, m_axis_tdata[40:30]);
          cmp_field("last_tile", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ent.attr_w = s_axis_tdata[15:0];
        ent.tile_w = s_axis_tdata[31:16];
        ent.pos_w  = s_axis_tdata[47:32];
        ent.odd    = s_axis_tuser[0];
        ent.first  = s_axis_tuser[1];
        predict_tiles(ent);
      end
    end
  end

  // ----------------------------------------------------------------- stimulus

  function automatic logic [15:0] head_attr(bit head, bit fy, bit fx, logic [1:0] hlog,
                                            logic [1:0] wlog, logic [8:0] y);
    return {head, fy, fx, hlog, wlog, y};
  endfunction

  function automatic logic [15:0] pos_word(logic [3:0] color, bit flash, logic [8:0] x);
    return {color, flash, 2'b00, x};
  endfunction

  task automatic push_entry(logic [15:0] aw, logic [15:0] tw, logic [15:0] pw, bit odd,
                            bit first);
    list_entry_t e;
    e.attr_w = aw;
    e.tile_w = tw;
    e.pos_w  = pw;
    e.odd    = odd;
    e.first  = first;
    entry_q.push_back(e);
    entries_made++;
  endtask

  // Continuation entries: their words are ignored, so fill them with noise
  task automatic push_continuations(int n);
    logic [15:0] aw;
    for (int i = 0; i < n; i++) begin
      aw = 16'($urandom_range(16'hffff));
      aw[15] = 1'b0;
      push_entry(aw, 16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)),
                 1'($urandom_range(1)), $urandom_range(29) == 0);
    end
  endtask

  // One sprite: head plus its continuations, sometimes cut short or overrun.
  // A wide tail leaves columns pending across the next register change.
  task automatic push_random_sprite(bit wide_tail);
    logic [15:0] aw;
    logic [15:0] pw;
    logic [3:0]  color;
    int          ncols;
    aw = 16'($urandom_range(16'hffff));
    aw[15] = wide_tail || ($urandom_range(4) != 0);
    if (wide_tail) aw[10:9] = 2'd3;
    // mostly pick colors that pass the priority test, where the value fits the mask
    if ($urandom_range(3) != 0)
      color = (cfg_prio_value & cfg_prio_mask) | (4'($urandom_range(15)) & ~cfg_prio_mask);
    else
      color = 4'($urandom_range(15));
    pw = 16'($urandom_range(16'hffff));
    pw[15:12] = color;
    push_entry(aw, 16'($urandom_range(16'hffff)), pw, 1'($urandom_range(1)),
               !wide_tail && $urandom_range(19) == 0);
    ncols = (1 << aw[10:9]) - 1;
    if (wide_tail) begin
      ncols = 2;
    end else begin
      case ($urandom_range(9))
        0: ncols = $urandom_range(ncols);
        1: ncols = ncols + $urandom_range(2, 1);
        default: ;
      endcase
    end
    push_continuations(ncols);
  endtask

  task automatic random_part(int n);
    int target;
    target = entries_made + n;
    while (entries_made < target) push_random_sprite(1'b0);
    push_random_sprite(1'b1);
  endtask

  // Wait for the emitter to drain, including a suppressed column still in work
  task automatic wait_idle();
    while (entry_q.size() != 0 || s_axis_tvalid || tiles_due.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
  endtask

  task automatic set_config(bit flip, logic [3:0] mask, logic [3:0] value);
    write_reg(CfgFlipScreen, {3'b000, flip});
    write_reg(CfgPriorityMask, mask);
    write_reg(CfgPriorityValue, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(bit flip, logic [3:0] mask, logic [3:0] value, int n);
    wait_idle();
    set_config(flip, mask, value);
    // finish the wide sprite left open by the previous phase
    push_continuations(5);
    random_part(n);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgFlipScreen;
    cfg_data_i = '0;
    cfg_flip = 1'b0;
    cfg_prio_mask = '0;
    cfg_prio_value = '0;
    cols_left = '0;
    col_idx = '0;
    spr_code = '0;
    spr_color = '0;
    spr_flags = '0;
    spr_hlog = '0;
    spr_x = '0;
    spr_y = '0;
    entries_made = 0;
    err_count = 0;
    entry_gap = 0;
    ready_stall = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    entry_taken = 1'b0;
    tile_taken = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_config(1'b0, 4'h0, 4'h0);
    // smallest sprite at the origin
    push_entry(head_attr(1, 0, 0, 0, 0, 9'h000), 16'h0000, pos_word(0, 0, 9'h000), 0, 0);
    // 8x8, both flips, flashing on an odd frame, all-ones attribute and tile words
    push_entry(head_attr(1, 1, 1, 3, 3, 9'h1ff), 16'hffff, pos_word(15, 1, 9'h1ff), 1, 0);
    push_entry(16'h7fff, 16'hffff, 16'hffff, 1, 0);
    // flashing on an even frame: column dropped but still counted
    push_entry(16'h0000, 16'h0000, 16'h0000, 0, 0);
    // forced head by first_of_list in the middle of a sprite
    push_entry(head_attr(0, 0, 1, 2, 1, 9'h0ff), 16'h1ffe, pos_word(5, 0, 9'h100), 0, 1);
    // new-sprite bit in the middle of a sprite
    push_entry(head_attr(1, 1, 0, 1, 2, 9'h100), 16'h0001, pos_word(10, 0, 9'h0ff), 1, 0);
    push_continuations(3);
    // no columns left: bit 15 clear still decodes as a head
    push_entry(head_attr(0, 0, 0, 1, 0, 9'h080), 16'hbaaa,
               pos_word(3, 1, 9'h07f) | 16'h0600, 1, 0);
    // 8x8 from the top code: codes wrap past 8191
    push_entry(head_attr(1, 0, 0, 3, 3, 9'h001), 16'h1fff, pos_word(9, 0, 9'h001), 0, 0);
    push_continuations(7);
    random_part(80);

    run_phase(1'b1, 4'hf, 4'hf, 100);
    run_phase(1'b0, 4'hc, 4'h4, 90);
    run_phase(1'b1, 4'h0, 4'h0, 70);
    run_phase(1'b0, 4'h0, 4'hf, 30);
    wait_idle();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
design/slte_pkg.sv
design/slte_head_decode.sv
design/slte_tile_unit.sv
design/sprite_list_tile_emitter.sv
bench/tb.sv
